@@ design/circular_deque_macros.svh @@
// Assertion macros for the deque. Each one samples on the rising edge of clk
// and is switched off while arst_n is low.
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

`ifndef ASSERT_OFF

// The condition holds at every clock edge.
`define DQ_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("deque assertion failed");

// The consequent holds in the cycle after the trigger.
`define DQ_ASSERT_NEXT(label, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error("deque assertion failed");

`else

`define DQ_ASSERT(label, cond)
`define DQ_ASSERT_NEXT(label, trig, cons)

`endif

`endif

@@ design/cdq_pkg.sv @@
package cdq_pkg;

	// Ring geometry and word width.
	localparam int DEPTH     = 64;
	localparam int DATA_BITS = 32;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);

	// Fixed port widths.
	localparam int OP_W     = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int CAP_W    = 7;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [DATA_BITS-1:0] word_t;

endpackage

@@ design/circular_deque.sv @@
// Double-ended queue of words held in a ring memory, of which the first
// "capacity" entries are in use. Each operation word (push back, push front,
// pop front, pop back or query) returns one result word with the status, the
// count and both end words after the step. The accept edge updates the
// indices, writes a pushed word and launches the reads of both ends from the
// ring memory, which has a synchronous read; the read data then moves into
// the result register as soon as that register is empty or being taken. A new
// operation is accepted only once the last one has reached the result register;
// a result may wait in its register while the next operation is accepted.
// Writing the capacity (0 is taken as 1, values above the ring depth as the
// depth) empties the deque at once; there is no clearing pass after reset,
// since an entry is only ever read after it has been written.
`include "circular_deque_macros.svh"

module circular_deque import cdq_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	// Operation channel
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [OP_W-1:0]            operation,
	input  logic signed [VALUE_W-1:0]  value,
	// Result channel
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [STATUS_W-1:0]        status,
	output logic [CAP_W-1:0]           count,
	output logic                       ends_valid,
	output logic signed [VALUE_W-1:0]  front_value,
	output logic signed [VALUE_W-1:0]  back_value,
	// Capacity write channel
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CAP_W-1:0]           capacity
);

	// Control state.
	idx_t  front_q;
	idx_t  back_q;
	cnt_t  occ_q;
	cnt_t  cap_q;
	logic  busy_q;
	logic  out_valid_q;

	// Stage one: memory read data and what travels beside it.
	word_t                 rd_front_s1;
	word_t                 rd_back_s1;
	word_t                 word_s1;
	logic                  fwd_front_s1;
	logic                  fwd_back_s1;
	logic [STATUS_W-1:0]   status_s1;
	cnt_t                  occ_s1;

	// Result register.
	logic [STATUS_W-1:0]   status_q;
	cnt_t                  count_q;
	logic                  ends_valid_q;
	word_t                 front_word_q;
	word_t                 back_word_q;

	// Ring memory.
	word_t ring_mem [DEPTH];

	logic                  accept;
	logic                  load_out;
	logic                  cfg_accept;
	logic                  full;
	logic                  empty;
	logic                  we;
	idx_t                  wr_addr;
	word_t                 wr_data;
	idx_t                  front_n;
	idx_t                  back_n;
	cnt_t                  occ_n;
	logic [STATUS_W-1:0]   status_n;
	idx_t                  rd_front_addr;
	idx_t                  rd_back_addr;
	cnt_t                  cap_clamped;
	logic [CNT_W:0]        ring_sum;
	idx_t                  back_expect;

	// Next index around the ring in use.
	function automatic idx_t ring_next(idx_t i, cnt_t cap);
		logic [CNT_W:0] inc;
		inc = {1'b0, CNT_W'(i)} + (CNT_W+1)'(1);
		return (inc >= {1'b0, cap}) ? '0 : IDX_W'(inc);
	endfunction

	// Previous index around the ring in use.
	function automatic idx_t ring_prev(idx_t i, cnt_t cap);
		cnt_t last;
		last = cap - CNT_W'(1);
		return (i == '0 || CNT_W'(i) >= cap) ? IDX_W'(last) : i - IDX_W'(1);
	endfunction

	// Clamp a written capacity into one to the ring depth.
	function automatic cnt_t clamp_cap(logic [CAP_W-1:0] v);
		if (v == '0) begin
			return CNT_W'(1);
		end
		if (32'(v) > 32'(DEPTH)) begin
			return CNT_W'(DEPTH);
		end
		return CNT_W'(v);
	endfunction

	// A pending capacity write goes ahead of an operation word.
	assign accept     = in_valid && in_ready;
	assign load_out   = busy_q && (!out_valid_q || out_ready);
	assign cfg_accept = cfg_valid && cfg_ready;
	assign in_ready   = !busy_q && !cfg_valid;
	assign cfg_ready  = !busy_q;
	assign out_valid  = out_valid_q;

	assign full        = (occ_q >= cap_q);
	assign empty       = (occ_q == '0);
	assign wr_data     = DATA_BITS'($unsigned(value));
	assign cap_clamped = clamp_cap(capacity);

	// Work out the step: new indices, count, status and the write.
	always_comb begin
		front_n  = front_q;
		back_n   = back_q;
		occ_n    = occ_q;
		status_n = ST_DONE;
		we       = 1'b0;
		wr_addr  = back_q;
		case (operation)
			OP_PUSH_BACK: begin
				if (full) begin
					status_n = ST_FULL;
				end else begin
					we      = accept;
					wr_addr = back_q;
					back_n  = ring_next(back_q, cap_q);
					occ_n   = occ_q + CNT_W'(1);
				end
			end
			OP_PUSH_FRONT: begin
				if (full) begin
					status_n = ST_FULL;
				end else begin
					we      = accept;
					front_n = ring_prev(front_q, cap_q);
					wr_addr = front_n;
					occ_n   = occ_q + CNT_W'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status_n = ST_EMPTY;
				end else begin
					front_n = ring_next(front_q, cap_q);
					occ_n   = occ_q - CNT_W'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					status_n = ST_EMPTY;
				end else begin
					back_n = ring_prev(back_q, cap_q);
					occ_n  = occ_q - CNT_W'(1);
				end
			end
			default: begin
				status_n = ST_DONE;
			end
		endcase
	end

	// The ends after the step.
	assign rd_front_addr = front_n;
	assign rd_back_addr  = ring_prev(back_n, cap_q);

	// Ring memory: write a pushed word, read both ends on the same edge.
	always_ff @(posedge clk) begin
		if (we) begin
			ring_mem[wr_addr] <= wr_data;
		end
		if (accept) begin
			rd_front_s1 <= ring_mem[rd_front_addr];
			rd_back_s1  <= ring_mem[rd_back_addr];
		end
	end

	// Side data for stage one, with forwarding of a word written on the read edge.
	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1      <= wr_data;
			fwd_front_s1 <= we && (rd_front_addr == wr_addr);
			fwd_back_s1  <= we && (rd_back_addr == wr_addr);
			status_s1    <= status_n;
			occ_s1       <= occ_n;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q     <= status_s1;
			count_q      <= occ_s1;
			ends_valid_q <= (occ_s1 != '0);
			if (occ_s1 == '0) begin
				front_word_q <= '0;
				back_word_q  <= '0;
			end else begin
				front_word_q <= fwd_front_s1 ? word_s1 : rd_front_s1;
				back_word_q  <= fwd_back_s1 ? word_s1 : rd_back_s1;
			end
		end
	end

	// Indices, count, capacity and handshake state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			back_q      <= '0;
			occ_q       <= '0;
			cap_q       <= clamp_cap(CAP_W'(64));
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_accept) begin
				cap_q   <= cap_clamped;
				front_q <= '0;
				back_q  <= '0;
				occ_q   <= '0;
			end else if (accept) begin
				front_q <= front_n;
				back_q  <= back_n;
				occ_q   <= occ_n;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (load_out) begin
				busy_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Drive the result ports.
	assign status      = status_q;
	assign count       = CAP_W'(count_q);
	assign ends_valid  = ends_valid_q;
	assign front_value = $signed(VALUE_W'(front_word_q));
	assign back_value  = $signed(VALUE_W'(back_word_q));

	// Where the back index must sit, given the front and the count.
	assign ring_sum    = {1'b0, CNT_W'(front_q)} + {1'b0, occ_q};
	assign back_expect = (ring_sum >= {1'b0, cap_q}) ? IDX_W'(ring_sum - {1'b0, cap_q})
	                                                 : IDX_W'(ring_sum);

	`DQ_ASSERT(a_occ_within_cap, occ_q <= cap_q)
	`DQ_ASSERT(a_ring_consistent, back_q == back_expect)
	`DQ_ASSERT_NEXT(a_accept_busy, accept, busy_q)
	`DQ_ASSERT(a_ends_flag, !out_valid_q || (ends_valid_q == (count_q != '0)))

endmodule

@@ tb/sv/deque_result_checker.sv @@
`timescale 1ns / 1ps

module deque_result_checker import cdq_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [OP_W-1:0]           operation,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [STATUS_W-1:0]       status,
	input  logic [CAP_W-1:0]          count,
	input  logic                      ends_valid,
	input  logic signed [VALUE_W-1:0] front_value,
	input  logic signed [VALUE_W-1:0] back_value,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CAP_W-1:0]          capacity,
	output int                        fail_count,
	output int                        pending
);

	// What one result word should carry.
	typedef struct {
		logic [STATUS_W-1:0]       st;
		logic [CAP_W-1:0]          held;
		logic                      ends;
		logic signed [VALUE_W-1:0] front;
		logic signed [VALUE_W-1:0] back;
	} deque_view_t;

	// Shadow copy of the ring, its pointers and the capacity in use.
	word_t       ring [DEPTH];
	idx_t        front_slot;
	idx_t        back_slot;
	cnt_t        held;
	cnt_t        slots;
	deque_view_t awaited [$];
	deque_view_t want;
	int          errors;

	function automatic idx_t slot_after(idx_t i);
		if (int'(i) + 1 >= int'(slots))
			return '0;
		return idx_t'(int'(i) + 1);
	endfunction

	function automatic idx_t slot_before(idx_t i);
		if (i == '0 || int'(i) >= int'(slots))
			return idx_t'(int'(slots) - 1);
		return idx_t'(int'(i) - 1);
	endfunction

	// A capacity write clamps to 1..DEPTH and empties the deque.
	function automatic void take_capacity(logic [CAP_W-1:0] v);
		if (v == '0)
			slots = cnt_t'(1);
		else if (int'(v) > DEPTH)
			slots = cnt_t'(DEPTH);
		else
			slots = cnt_t'(v);
		front_slot = '0;
		back_slot = '0;
		held = '0;
	endfunction

	// Applies one operation word to the shadow deque and returns the view after it.
	function automatic deque_view_t apply_op(logic [OP_W-1:0] op, word_t w);
		deque_view_t v;
		v.st = ST_DONE;
		case (op)
			OP_PUSH_BACK: begin
				if (held >= slots) begin
					v.st = ST_FULL;
				end else begin
					ring[back_slot] = w;
					back_slot = slot_after(back_slot);
					held = held + 1'b1;
				end
			end
			OP_PUSH_FRONT: begin
				if (held >= slots) begin
					v.st = ST_FULL;
				end else begin
					front_slot = slot_before(front_slot);
					ring[front_slot] = w;
					held = held + 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (held == '0) begin
					v.st = ST_EMPTY;
				end else begin
					front_slot = slot_after(front_slot);
					held = held - 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (held == '0) begin
					v.st = ST_EMPTY;
				end else begin
					back_slot = slot_before(back_slot);
					held = held - 1'b1;
				end
			end
			// Query and the unused codes leave the deque alone.
			default: ;
		endcase
		v.held = CAP_W'(held);
		v.ends = (held != '0);
		if (held != '0) begin
			v.front = ring[front_slot];
			v.back = ring[slot_before(back_slot)];
		end else begin
			v.front = '0;
			v.back = '0;
		end
		return v;
	endfunction

	function automatic void check_field(string name, logic [VALUE_W-1:0] exp_val,
		logic [VALUE_W-1:0] act_val);
		if (act_val !== exp_val) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, name, exp_val,
				act_val);
		end
	endfunction

	// Results are checked before this edge's operation word is predicted, since the
	// block never hands over a result word at the edge that takes its operation word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			take_capacity(CAP_W'(DEPTH));
			awaited.delete();
			errors = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited.size() == 0) begin
					errors++;
					$display("%0t ns: expected no result word, got status %h count %0d",
						$time, status, count);
				end else begin
					want = awaited.pop_front();
					check_field("status", want.st, status);
					check_field("count", want.held, count);
					check_field("ends_valid", want.ends, ends_valid);
					check_field("front_value", want.front, front_value);
					check_field("back_value", want.back, back_value);
				end
			end
			if (cfg_valid && cfg_ready)
				take_capacity(capacity);
			if (in_valid && in_ready)
				awaited.push_back(apply_op(operation, value));
			fail_count <= errors;
			pending <= awaited.size();
		end
	end

endmodule

@@ tb/sv/circular_deque_test.sv @@
`timescale 1ns / 1ps

module circular_deque_test import cdq_pkg::*; ();

	// Codes the package does not name.
	localparam logic [OP_W-1:0] OP_QUERY        = 3'd4;
	localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASES       = 13;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic [OP_W-1:0]           operation = OP_QUERY;
	logic signed [VALUE_W-1:0] value = '0;
	logic                      out_ready = 1'b0;
	logic                      cfg_valid = 1'b0;
	logic [CAP_W-1:0]          capacity = CAP_W'(DEPTH);
	logic                      in_ready;
	logic                      out_valid;
	logic [STATUS_W-1:0]       status;
	logic [CAP_W-1:0]          count;
	logic                      ends_valid;
	logic signed [VALUE_W-1:0] front_value;
	logic signed [VALUE_W-1:0] back_value;
	logic                      cfg_ready;
	int                        fail_count;
	int                        pending;
	bit                        quiet_sender = 1'b0;

	circular_deque DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.count      (count),
		.ends_valid (ends_valid),
		.front_value(front_value),
		.back_value (back_value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.capacity   (capacity)
	);

	deque_result_checker CHECK (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.count      (count),
		.ends_valid (ends_valid),
		.front_value(front_value),
		.back_value (back_value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.capacity   (capacity),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Random words with the extremes mixed in.
	function automatic logic signed [VALUE_W-1:0] pick_word();
		if ($urandom_range(0, 9) != 0)
			return $urandom;
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return {1'b0, {(VALUE_W - 1){1'b1}}};
			3: return {1'b1, {(VALUE_W - 1){1'b0}}};
			default: return VALUE_W'(1);
		endcase
	endfunction

	// While filling, pushes dominate; while emptying, pops do.
	function automatic logic [OP_W-1:0] pick_op(bit filling);
		int r;
		bit push;
		r = $urandom_range(0, 99);
		if (r >= 97)
			return OP_QUERY + OP_W'($urandom_range(0, OP_UNUSED_LAST - OP_QUERY));
		push = (r < 90) ? filling : !filling;
		if (push)
			return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
		return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
	endfunction

	// Offers one operation word and returns at the edge that takes it.
	task automatic send_word(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] w);
		int gap;
		gap = quiet_sender ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		value <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	// Holds off the sender until every expected result word has been taken.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] v);
		cfg_valid <= 1'b1;
		capacity <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Result side: runs of readiness broken by stalls, with some long clean runs.
	initial begin
		int run;
		int gap;
		@(posedge clk);
		forever begin
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// Ends the run when no word moves on any channel for too long.
	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
		$display("circular_deque verification failed");
		$finish;
	end

	initial begin
		logic [CAP_W-1:0] plan [0:PHASES-1];
		int p;
		int k;
		int n;
		int left;
		int usable;
		bit filling;

		plan = '{7'd2, 7'd64, 7'd5, 7'd1, 7'd127, 7'd17, 7'd0, 7'd64, 7'd3, 7'd40, 7'd8,
			7'd65, 7'd0};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A zero capacity leaves one slot: refusals on both sides, all query codes.
		write_capacity('0);
		send_word(OP_POP_FRONT, pick_word());
		send_word(OP_POP_BACK, pick_word());
		send_word(OP_QUERY, pick_word());
		send_word(OP_PUSH_BACK, {1'b0, {(VALUE_W - 1){1'b1}}});
		send_word(OP_PUSH_FRONT, {1'b1, {(VALUE_W - 1){1'b0}}});
		send_word(OP_PUSH_BACK, '1);
		send_word(OP_UNUSED_FIRST, pick_word());
		send_word(OP_UNUSED_FIRST + 1'b1, pick_word());
		send_word(OP_UNUSED_LAST, pick_word());
		send_word(OP_POP_BACK, pick_word());
		send_word(OP_POP_FRONT, pick_word());

		// Largest register value clamps to the full ring; front pushes wrap at once.
		drain();
		write_capacity('1);
		send_word(OP_PUSH_FRONT, {1'b1, {(VALUE_W - 1){1'b0}}});
		send_word(OP_PUSH_BACK, '1);
		send_word(OP_PUSH_FRONT, '0);
		send_word(OP_POP_FRONT, pick_word());
		send_word(OP_POP_BACK, pick_word());
		send_word(OP_POP_BACK, pick_word());
		send_word(OP_POP_FRONT, pick_word());

		// Random phases: each starts by filling the deque, then swings between
		// filling and emptying so that both full and empty are hit repeatedly.
		for (p = 0; p < PHASES; p++) begin
			drain();
			if (p == PHASES - 1)
				plan[p] = CAP_W'($urandom_range(0, 127));
			write_capacity(plan[p]);
			usable = (plan[p] == '0) ? 1 : (int'(plan[p]) > DEPTH) ? DEPTH : int'(plan[p]);
			n = (p == PHASES - 1) ? 120 : (usable >= 32) ? 200 : 60;
			quiet_sender = ($urandom_range(0, 3) == 0);
			filling = 1'b1;
			left = usable + 8;
			for (k = 0; k < n; k++) begin
				if (left == 0) begin
					filling = !filling;
					left = $urandom_range(4, 2 * usable + 8);
				end
				left--;
				send_word(pick_op(filling), pick_word());
				if ($urandom_range(0, 149) == 0)
					drain();
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("circular_deque verification clean");
		else
			$display("circular_deque verification failed");
		$finish;
	end

endmodule
